[hdl/sts_pkg.sv]
// Shared types and constants for the sphere triangle subdivider.
// No dependencies; every other file refers to it by scoped names.
package sts_pkg;

    localparam int COORD_W    = 16;
    localparam int VEC_W      = 35;
    localparam int MAG_W      = 35;
    localparam int NORM_BIT   = 28;
    localparam int SQ_W       = 58;
    localparam int S_W        = 60;
    localparam int ROOT_W     = 30;
    localparam int SQRT_STEPS = 30;

    localparam logic [3:0] LAST_SPLIT = 4'd11;
    localparam logic [3:0] LAST_PASS  = 4'd2;

    typedef enum logic [1:0] {
        CFG_SPLIT  = 2'd0,
        CFG_EMIT   = 2'd1,
        CFG_SMOOTH = 2'd2
    } t_cfg_idx;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef t_coord [2:0] t_c3;
    typedef logic signed [VEC_W-1:0] t_comp;
    typedef t_comp [2:0] t_vec;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic signed [COORD_W-1:0] third_x;
        logic signed [COORD_W-1:0] third_y;
        logic signed [COORD_W-1:0] third_z;
    } t_tri;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] norm_x;
        logic signed [COORD_W-1:0] norm_y;
        logic signed [COORD_W-1:0] norm_z;
        logic                      normal_valid;
        logic                      last_vertex;
    } t_vtx;

    typedef struct packed {
        logic done;
        logic ok;
    } t_lane_stat;

endpackage

[hdl/sts_tri_if.sv]
// Input channel carrying one triangle request.
// Depends on sts_pkg for the payload type.
interface sts_tri_if;
    logic          valid;
    logic          ready;
    sts_pkg::t_tri data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/sts_vtx_if.sv]
// Output channel carrying one emitted vertex request.
// Depends on sts_pkg for the payload type.
interface sts_vtx_if;
    logic          valid;
    logic          ready;
    sts_pkg::t_vtx data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/sts_unitize.sv]
// Iterative vector normaliser: shift normalise, sum of squares,
// bit-serial square root and three bit-serial dividers. Depends on sts_pkg.
module sts_unitize #(
    parameter int COORD_FRAC_BITS = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  sts_pkg::t_vec       i_vec,
    output sts_pkg::t_lane_stat o_stat,
    output sts_pkg::t_c3        o_res
);
    localparam int QW    = COORD_FRAC_BITS + 1;
    localparam int CAP_I = (COORD_FRAC_BITS >= 15) ? 32767 : (1 << COORD_FRAC_BITS);
    localparam logic [QW-1:0] CAP = QW'(CAP_I);

    typedef enum logic [2:0] {S_IDLE, S_NORM, S_SQ, S_SQRT, S_PREP, S_DIV, S_FIN} t_state;

    t_state                        r_state;
    logic [4:0]                    r_k;
    logic [sts_pkg::MAG_W-1:0]     r_mag [3];
    logic                          r_neg [3];
    logic [sts_pkg::SQ_W-1:0]      r_prod;
    logic [sts_pkg::S_W-1:0]       r_s;
    logic [31:0]                   r_rem;
    logic [sts_pkg::ROOT_W-1:0]    r_root;
    logic [30:0]                   r_rdiv [3];
    logic [QW-1:0]                 r_low [3];
    logic [QW-1:0]                 r_q [3];
    logic                          r_ok;
    sts_pkg::t_c3                  r_res;

    logic [sts_pkg::MAG_W-1:0]     mag_or;
    logic [sts_pkg::MAG_W-1:0]     sel_mag;
    logic [sts_pkg::SQ_W-1:0]      sq;
    logic [33:0]                   rem2;
    logic [33:0]                   trial;
    logic                          sq_ge;
    logic [31:0]                   dvs;
    logic [31:0]                   dr2 [3];
    logic                          dge [3];
    logic [QW-1:0]                 qc [3];
    logic [sts_pkg::MAG_W-1:0]     in_mag [3];
    logic                          in_zero;

    always_comb begin
        mag_or  = r_mag[0] | r_mag[1] | r_mag[2];
        sel_mag = (r_k < 5'd3) ? r_mag[r_k[1:0]] : '0;
        sq      = sel_mag[28:0] * sel_mag[28:0];
        rem2    = {r_rem, r_s[sts_pkg::S_W-1 -: 2]};
        trial   = {2'b00, r_root, 2'b01};
        sq_ge   = rem2 >= trial;
        dvs     = {1'b0, r_root, 1'b0};
        in_zero = 1'b1;
        for (int i = 0; i < 3; i++) begin
            dr2[i]    = {r_rdiv[i], r_low[i][QW-1]};
            dge[i]    = dr2[i] >= dvs;
            qc[i]     = (r_q[i] > CAP) ? CAP : r_q[i];
            in_mag[i] = i_vec[i][sts_pkg::VEC_W-1] ? sts_pkg::MAG_W'(-i_vec[i])
                                                   : sts_pkg::MAG_W'(i_vec[i]);
            if (i_vec[i] != '0) in_zero = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ok    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= in_mag[i];
                            r_neg[i] <= i_vec[i][sts_pkg::VEC_W-1];
                        end
                        if (in_zero) begin
                            r_ok  <= 1'b0;
                            r_res <= '0;
                        end else begin
                            r_ok    <= 1'b1;
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    if (|mag_or[sts_pkg::MAG_W-1:sts_pkg::NORM_BIT+1]) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                    end else if (!mag_or[sts_pkg::NORM_BIT]) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                    end else begin
                        r_k     <= '0;
                        r_s     <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_prod <= sq;
                    if (r_k != 5'd0) r_s <= r_s + sts_pkg::S_W'(r_prod);
                    if (r_k == 5'd3) begin
                        r_k     <= '0;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_k <= r_k + 5'd1;
                    end
                end
                S_SQRT: begin
                    r_s <= r_s << 2;
                    if (sq_ge) begin
                        r_rem  <= 32'(rem2 - trial);
                        r_root <= {r_root[sts_pkg::ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= rem2[31:0];
                        r_root <= {r_root[sts_pkg::ROOT_W-2:0], 1'b0};
                    end
                    if (r_k == 5'(sts_pkg::SQRT_STEPS - 1)) r_state <= S_PREP;
                    else r_k <= r_k + 5'd1;
                end
                S_PREP: begin
                    for (int i = 0; i < 3; i++) begin
                        r_rdiv[i] <= 31'(r_mag[i]) + 31'(r_root >> QW);
                        r_low[i]  <= QW'(r_root);
                    end
                    r_k     <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        r_rdiv[i] <= dge[i] ? 31'(dr2[i] - dvs) : dr2[i][30:0];
                        r_q[i]    <= {r_q[i][QW-2:0], dge[i]};
                        r_low[i]  <= r_low[i] << 1;
                    end
                    if (r_k == 5'(QW - 1)) r_state <= S_FIN;
                    else r_k <= r_k + 5'd1;
                end
                S_FIN: begin
                    for (int i = 0; i < 3; i++) begin
                        r_res[i] <= r_neg[i] ? -sts_pkg::COORD_W'(qc[i])
                                             : sts_pkg::COORD_W'(qc[i]);
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stat.done = (r_state == S_IDLE);
    assign o_stat.ok   = r_ok;
    assign o_res       = r_res;

endmodule

[hdl/sts_face.sv]
// Face normal lane: registered edge cross product feeding a normaliser.
// Depends on sts_pkg and sts_unitize.
module sts_face #(
    parameter int COORD_FRAC_BITS = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  sts_pkg::t_c3        i_a,
    input  sts_pkg::t_c3        i_b,
    input  sts_pkg::t_c3        i_c,
    output sts_pkg::t_lane_stat o_stat,
    output sts_pkg::t_c3        o_res
);
    logic                r_go;
    logic signed [33:0]  r_p [6];
    logic signed [16:0]  e1 [3];
    logic signed [16:0]  e2 [3];
    sts_pkg::t_vec       cr;
    sts_pkg::t_lane_stat u_stat;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e1[i] = 17'(i_b[i]) - 17'(i_a[i]);
            e2[i] = 17'(i_c[i]) - 17'(i_a[i]);
        end
        cr[0] = sts_pkg::VEC_W'(r_p[0]) - sts_pkg::VEC_W'(r_p[1]);
        cr[1] = sts_pkg::VEC_W'(r_p[2]) - sts_pkg::VEC_W'(r_p[3]);
        cr[2] = sts_pkg::VEC_W'(r_p[4]) - sts_pkg::VEC_W'(r_p[5]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else begin
            r_go <= i_start;
        end
        if (i_start) begin
            r_p[0] <= e1[1] * e2[2];
            r_p[1] <= e1[2] * e2[1];
            r_p[2] <= e1[2] * e2[0];
            r_p[3] <= e1[0] * e2[2];
            r_p[4] <= e1[0] * e2[1];
            r_p[5] <= e1[1] * e2[0];
        end
    end

    sts_unitize #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_vec   (cr),
        .o_stat  (u_stat),
        .o_res   (o_res)
    );

    assign o_stat.done = u_stat.done && !r_go;
    assign o_stat.ok   = u_stat.ok;

endmodule

[hdl/sphere_triangle_subdivider.sv]
// Top level of the sphere triangle subdivider: three midpoint lanes, four
// face normal lanes and the vertex emitter. Depends on sts_pkg, the channel
// interfaces, sts_unitize and sts_face.
//
// A triangle moves through three stages: midpoint lanes, face normal lanes,
// then an emit buffer that sends one vertex a cycle while o_vtx is ready
// (twelve when splitting, three when passing through). The stages overlap,
// so the sustained rate is set by the slowest stage. Each normalisation
// lane is iterative: up to 28 shift steps and one settling step, 4
// sum-of-squares steps, 30 square-root steps and COORD_FRAC_BITS + 3
// division and saturation steps. Ahead of its normaliser the face stage
// registers its start and its cross-product terms. The face lanes run only
// with flat normals and the midpoint lanes only when splitting. The emit
// buffer is refilled in the cycle after its last vertex leaves. No clearing
// pass.
module sphere_triangle_subdivider #(
    parameter int COORD_FRAC_BITS = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic      i_cfg_data,
    sts_tri_if.sink   i_tri,
    sts_vtx_if.source o_vtx
);
    logic r_split;
    logic r_emit;
    logic r_smooth;

    logic          r_a_full;
    sts_pkg::t_c3  r_a_v [3];
    logic          r_b_full;
    logic          r_b_go;
    sts_pkg::t_c3  r_b_v [6];
    logic          r_c_full;
    logic [3:0]    r_cnt;
    logic [1:0]    r_tri_idx;
    logic [1:0]    r_k;
    sts_pkg::t_c3  r_c_pos [12];
    sts_pkg::t_c3  r_c_nrm [4];
    logic          r_c_ok [4];

    sts_pkg::t_c3        tin [3];
    sts_pkg::t_vec       mid_vec [3];
    sts_pkg::t_lane_stat mid_stat [3];
    sts_pkg::t_c3        mid_res [3];
    sts_pkg::t_c3        tv [4][3];
    sts_pkg::t_lane_stat face_stat [4];
    sts_pkg::t_c3        face_res [4];

    logic         in_fire;
    logic         out_fire;
    logic         mid_start;
    logic         a_to_b;
    logic         b_to_c;
    logic         mids_done;
    logic         faces_done;
    logic [3:0]   last_idx;
    sts_pkg::t_c3 cur_pos;
    sts_pkg::t_c3 cur_nrm;
    logic         cur_ok;

    always_comb begin
        tin[0][0] = i_tri.data.first_x;
        tin[0][1] = i_tri.data.first_y;
        tin[0][2] = i_tri.data.first_z;
        tin[1][0] = i_tri.data.second_x;
        tin[1][1] = i_tri.data.second_y;
        tin[1][2] = i_tri.data.second_z;
        tin[2][0] = i_tri.data.third_x;
        tin[2][1] = i_tri.data.third_y;
        tin[2][2] = i_tri.data.third_z;
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                mid_vec[j][i] = sts_pkg::VEC_W'(tin[j][i])
                              + sts_pkg::VEC_W'(tin[(j + 1) % 3][i]);
            end
        end
    end

    assign i_tri.ready = !r_a_full;
    assign in_fire     = i_tri.valid && !r_a_full;
    assign mid_start   = in_fire && r_split;

    for (genvar g = 0; g < 3; g++) begin : g_mid
        sts_unitize #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_mid (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (mid_start),
            .i_vec   (mid_vec[g]),
            .o_stat  (mid_stat[g]),
            .o_res   (mid_res[g])
        );
    end

    // b_v order: a, b, c, ab, bc, ca
    always_comb begin
        if (r_split) begin
            tv[0][0] = r_b_v[0]; tv[0][1] = r_b_v[3]; tv[0][2] = r_b_v[5];
            tv[1][0] = r_b_v[3]; tv[1][1] = r_b_v[1]; tv[1][2] = r_b_v[4];
            tv[2][0] = r_b_v[5]; tv[2][1] = r_b_v[4]; tv[2][2] = r_b_v[2];
            tv[3][0] = r_b_v[3]; tv[3][1] = r_b_v[4]; tv[3][2] = r_b_v[5];
        end else begin
            for (int t = 0; t < 4; t++) begin
                tv[t][0] = r_b_v[0]; tv[t][1] = r_b_v[1]; tv[t][2] = r_b_v[2];
            end
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_face
        sts_face #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_face (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_b_go),
            .i_a     (tv[g][0]),
            .i_b     (tv[g][1]),
            .i_c     (tv[g][2]),
            .o_stat  (face_stat[g]),
            .o_res   (face_res[g])
        );
    end

    always_comb begin
        mids_done  = 1'b1;
        faces_done = 1'b1;
        for (int i = 0; i < 3; i++) mids_done = mids_done && mid_stat[i].done;
        for (int i = 0; i < 4; i++) faces_done = faces_done && face_stat[i].done;
    end

    assign a_to_b   = r_a_full && mids_done && !r_b_full;
    assign b_to_c   = r_b_full && !r_b_go && faces_done && !r_c_full;
    assign last_idx = r_split ? sts_pkg::LAST_SPLIT : sts_pkg::LAST_PASS;
    assign out_fire = r_c_full && o_vtx.ready;

    always_comb begin
        cur_pos = r_c_pos[r_cnt];
        if (!r_emit) begin
            cur_nrm = '0;
            cur_ok  = 1'b0;
        end else if (r_smooth) begin
            cur_nrm = cur_pos;
            cur_ok  = |cur_pos;
        end else begin
            cur_nrm = r_c_nrm[r_tri_idx];
            cur_ok  = r_c_ok[r_tri_idx];
        end
    end

    assign o_vtx.valid             = r_c_full;
    assign o_vtx.data.pos_x        = cur_pos[0];
    assign o_vtx.data.pos_y        = cur_pos[1];
    assign o_vtx.data.pos_z        = cur_pos[2];
    assign o_vtx.data.norm_x       = cur_nrm[0];
    assign o_vtx.data.norm_y       = cur_nrm[1];
    assign o_vtx.data.norm_z       = cur_nrm[2];
    assign o_vtx.data.normal_valid = cur_ok;
    assign o_vtx.data.last_vertex  = (r_cnt == last_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split  <= 1'b1;
            r_emit   <= 1'b1;
            r_smooth <= 1'b0;
            r_a_full <= 1'b0;
            r_b_full <= 1'b0;
            r_b_go   <= 1'b0;
            r_c_full <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sts_pkg::CFG_SPLIT:  r_split  <= i_cfg_data;
                    sts_pkg::CFG_EMIT:   r_emit   <= i_cfg_data;
                    sts_pkg::CFG_SMOOTH: r_smooth <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_fire) r_a_full <= 1'b1;
            else if (a_to_b) r_a_full <= 1'b0;
            r_b_go <= a_to_b && r_emit && !r_smooth;
            if (a_to_b) r_b_full <= 1'b1;
            else if (b_to_c) r_b_full <= 1'b0;
            if (b_to_c) begin
                r_c_full <= 1'b1;
            end else if (out_fire && r_cnt == last_idx) begin
                r_c_full <= 1'b0;
            end
        end
        if (in_fire) begin
            for (int i = 0; i < 3; i++) r_a_v[i] <= tin[i];
        end
        if (a_to_b) begin
            for (int i = 0; i < 3; i++) begin
                r_b_v[i]     <= r_a_v[i];
                r_b_v[i + 3] <= mid_res[i];
            end
        end
        if (b_to_c) begin
            for (int t = 0; t < 4; t++) begin
                for (int k = 0; k < 3; k++) r_c_pos[t * 3 + k] <= tv[t][k];
                r_c_nrm[t] <= face_res[t];
                r_c_ok[t]  <= face_stat[t].ok;
            end
            r_cnt     <= '0;
            r_tri_idx <= '0;
            r_k       <= '0;
        end else if (out_fire) begin
            r_cnt <= r_cnt + 4'd1;
            if (r_k == 2'd2) begin
                r_k       <= '0;
                r_tri_idx <= r_tri_idx + 2'd1;
            end else begin
                r_k <= r_k + 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_full |-> (r_cnt <= last_idx))
        else $error("emit counter beyond last vertex");
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_vtx.data.last_vertex) |=> !r_c_full)
        else $error("emit buffer still full after last vertex");
    a_norm_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx.valid && o_vtx.data.normal_valid) |-> r_emit)
        else $error("normal flagged valid while normals disabled");
    a_go_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_go |-> (r_b_full && !b_to_c))
        else $error("face lanes started without a held triangle");
`endif

endmodule
